>>> rtl/hdlc_pkg.sv
// ----------------------------------------------------------------------------
// hdlc_pkg
// Shared constants, types and bit-level functions of the HDLC transmit framer.
// ----------------------------------------------------------------------------
`default_nettype none

package hdlc_pkg;

  localparam int DataW  = 8;
  localparam int ChunkW = 10;
  localparam int LenW   = 4;
  localparam int RunW   = 3;
  localparam int CrcW   = 16;

  localparam logic [DataW-1:0]  FLAG_BYTE = 8'h7E;
  localparam logic [CrcW-1:0]   CRC_INIT  = 16'hFFFF;
  localparam logic [CrcW-1:0]   CRC_POLY  = 16'h8408;
  localparam logic [LenW-1:0]   FLAG_LEN  = 4'd8;
  localparam logic [RunW-1:0]   RUN_LIMIT = 3'd5;

  localparam logic OP_IDLE = 1'b0;
  localparam logic OP_BYTE = 1'b1;

  typedef struct packed {
    logic [ChunkW-1:0] bits;
    logic [LenW-1:0]   len;
    logic [RunW-1:0]   run;
  } stuff_t;

  function automatic logic [CrcW-1:0] crc_update(input logic [CrcW-1:0] crc,
                                                 input logic [DataW-1:0] b);
    logic [CrcW-1:0] c;
    c = crc ^ {{(CrcW-DataW){1'b0}}, b};
    for (int i = 0; i < DataW; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // A zero is inserted after five ones in a row, counting the run carried in.
  function automatic stuff_t stuff_byte(input logic [DataW-1:0] b,
                                        input logic [RunW-1:0] run_in);
    stuff_t          r;
    logic [LenW-1:0] n;
    logic [RunW-1:0] run;
    r.bits = '0;
    n      = '0;
    run    = run_in;
    for (int i = 0; i < DataW; i++) begin
      r.bits[n] = b[i];
      n = n + 4'd1;
      if (b[i]) begin
        run = run + 3'd1;
        if (run >= RUN_LIMIT) begin
          n   = n + 4'd1;
          run = '0;
        end
      end else begin
        run = '0;
      end
    end
    r.len = n;
    r.run = run;
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/hdlc_if.sv
// ----------------------------------------------------------------------------
// hdlc_if
// Valid/ready channels of the framer: input words and line-bit chunk words.
// ----------------------------------------------------------------------------
`default_nettype none

interface hdlc_item_if;
  import hdlc_pkg::*;

  logic             valid;
  logic             ready;
  logic             operation;
  logic [DataW-1:0] data;
  logic             last_byte;

  modport source (output valid, operation, data, last_byte, input ready);
  modport sink   (input valid, operation, data, last_byte, output ready);
endinterface

interface hdlc_chunk_if;
  import hdlc_pkg::*;

  logic              valid;
  logic              ready;
  logic [ChunkW-1:0] line_bits;
  logic [LenW-1:0]   chunk_length;
  logic              last_of_run;

  modport source (output valid, line_bits, chunk_length, last_of_run, input ready);
  modport sink   (input valid, line_bits, chunk_length, last_of_run, output ready);
endinterface

`default_nettype wire

>>> rtl/hdlc_tx_framer.sv
// ----------------------------------------------------------------------------
// hdlc_tx_framer
// HDLC transmit framer: flags, CRC-16 FCS and zero bit stuffing per byte.
// ----------------------------------------------------------------------------
//  channel  | dir | words
//  item_i   | in  | operation, data, last_byte
//  chunk_o  | out | line_bits, chunk_length, last_of_run
//
// At most one chunk leaves the sequencer per cycle, none while chunk_o stalls:
// a byte inside a frame gives one chunk, a first byte a flag and its data, a
// later last byte its data and both FCS bytes; an idle tick in a frame, none.
// Reset returns the framer to idle between frames with the CRC at 0xFFFF.
// A stalled output register holds its word and the sequencer waits with it.
// ----------------------------------------------------------------------------
`default_nettype none

module hdlc_tx_framer (
  input  wire          clk_i,
  input  wire          rst_ni,
  hdlc_item_if.sink    item_i,
  hdlc_chunk_if.source chunk_o
);
  import hdlc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_START  = 5'b00010,
    S_DATA   = 5'b00100,
    S_FCS_LO = 5'b01000,
    S_FCS_HI = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  logic              in_frame_q, in_frame_d;
  logic              first_q, first_d;
  logic [CrcW-1:0]   crc_q, crc_d;
  logic [RunW-1:0]   run_q, run_d;
  logic              op_q;
  logic [DataW-1:0]  data_q;
  logic              last_q;

  logic              out_valid_q, out_valid_d;
  logic [ChunkW-1:0] out_bits_q;
  logic [LenW-1:0]   out_len_q;
  logic              out_last_q;

  logic              adv;
  logic              done;
  logic              emit;
  logic              do_data;
  logic [ChunkW-1:0] em_bits;
  logic [LenW-1:0]   em_len;
  logic              em_last;
  logic              accept;
  stuff_t            st;
  logic [DataW-1:0]  st_byte;

  assign adv    = !out_valid_q || chunk_o.ready;
  assign accept = item_i.valid && item_i.ready;
  assign item_i.ready = (state_q == S_IDLE) || done;

  always_comb begin
    state_d    = state_q;
    in_frame_d = in_frame_q;
    first_d    = first_q;
    crc_d      = crc_q;
    run_d      = run_q;
    done       = 1'b0;
    emit       = 1'b0;
    do_data    = 1'b0;
    em_bits    = {{(ChunkW-DataW){1'b0}}, FLAG_BYTE};
    em_len     = FLAG_LEN;
    em_last    = 1'b0;
    st_byte    = data_q;

    unique case (state_q)
      S_IDLE: begin
      end
      S_START: begin
        if (op_q == OP_IDLE) begin
          if (in_frame_q) begin
            done = 1'b1;
          end else if (adv) begin
            emit    = 1'b1;
            em_last = 1'b1;
            run_d   = '0;
            done    = 1'b1;
          end
        end else if (!in_frame_q) begin
          if (adv) begin
            emit       = 1'b1;
            run_d      = '0;
            crc_d      = CRC_INIT;
            in_frame_d = 1'b1;
            first_d    = 1'b1;
            state_d    = S_DATA;
          end
        end else begin
          do_data = 1'b1;
        end
      end
      S_DATA: begin
        do_data = 1'b1;
      end
      S_FCS_LO: begin
        st_byte = ~crc_q[DataW-1:0];
      end
      S_FCS_HI: begin
        st_byte = ~crc_q[CrcW-1:DataW];
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    st = stuff_byte(st_byte, run_q);

    if (adv) begin
      if (do_data) begin
        emit    = 1'b1;
        em_bits = st.bits;
        em_len  = st.len;
        run_d   = st.run;
        crc_d   = crc_update(crc_q, data_q);
        if (last_q && !first_q) begin
          state_d = S_FCS_LO;
        end else begin
          em_last = 1'b1;
          done    = 1'b1;
        end
      end else if (state_q == S_FCS_LO) begin
        emit    = 1'b1;
        em_bits = st.bits;
        em_len  = st.len;
        run_d   = st.run;
        state_d = S_FCS_HI;
      end else if (state_q == S_FCS_HI) begin
        emit       = 1'b1;
        em_bits    = st.bits;
        em_len     = st.len;
        em_last    = 1'b1;
        run_d      = st.run;
        in_frame_d = 1'b0;
        done       = 1'b1;
      end
    end

    if (done) begin
      state_d = S_IDLE;
    end
    if (accept) begin
      state_d = S_START;
      first_d = 1'b0;
    end

    if (emit) begin
      out_valid_d = 1'b1;
    end else if (chunk_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_frame_q  <= 1'b0;
      first_q     <= 1'b0;
      crc_q       <= CRC_INIT;
      run_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_frame_q  <= in_frame_d;
      first_q     <= first_d;
      crc_q       <= crc_d;
      run_q       <= run_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= item_i.operation;
      data_q <= item_i.data;
      last_q <= item_i.last_byte;
    end
    if (emit) begin
      out_bits_q <= em_bits;
      out_len_q  <= em_len;
      out_last_q <= em_last;
    end
  end

  assign chunk_o.valid        = out_valid_q;
  assign chunk_o.line_bits    = out_bits_q;
  assign chunk_o.chunk_length = out_len_q;
  assign chunk_o.last_of_run  = out_last_q;

endmodule

`default_nettype wire
